/* design/assert_macros.svh */
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

/* design/mlsd_pkg.sv */
// types and constants shared by the marker/length/sum deframer
`timescale 1ns / 1ps
package mlsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 8'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    // status codes
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;

    // classified byte as held in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_start;
        logic              is_end;
        logic              is_zero;
    } entry_t;

endpackage

/* design/mlsd_front.sv */
// front end: configuration registers, input beat acceptance and byte classification
`timescale 1ns / 1ps
module mlsd_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mlsd_pkg::BYTE_W-1:0]        s_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mlsd_pkg::BYTE_W-1:0]        cfg_data,
    input  logic                               queue_full,
    output logic                               push,
    output mlsd_pkg::entry_t                   push_entry
);

    logic [mlsd_pkg::BYTE_W-1:0] start_marker_reg;
    logic [mlsd_pkg::BYTE_W-1:0] end_marker_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb begin
        push_entry.data     = s_axis_tdata;
        push_entry.is_start = (s_axis_tdata == start_marker_reg);
        push_entry.is_end   = (s_axis_tdata == end_marker_reg);
        push_entry.is_zero  = (s_axis_tdata == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= mlsd_pkg::START_MARKER_RST;
            end_marker_reg   <= mlsd_pkg::END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mlsd_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                mlsd_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* design/mlsd_queue.sv */
// short queue of classified bytes between front and back ends
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mlsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mlsd_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mlsd_pkg::entry_t  head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mlsd_pkg::entry_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_CLK(a_count_up, aclk, aresetn, (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "queue count did not follow a lone push")
    `ASSERT_CLK(a_pop_nonempty, aclk, aresetn, pop |-> (count_reg != '0), "queue popped while empty")

endmodule

/* design/mlsd_back.sv */
// back end: deframing state machine, running sum and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mlsd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  mlsd_pkg::entry_t                  head_entry,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mlsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // payload_byte, payload_index, command_id, payload_length
    output logic [mlsd_pkg::OUT_USER_W-1:0]   m_axis_tuser   // status, payload_valid
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_END
    } phase_t;

    phase_t                          phase_reg,  phase_next;
    logic [mlsd_pkg::BYTE_W-1:0]     sum_reg,    sum_next;
    logic [mlsd_pkg::BYTE_W-1:0]     remain_reg, remain_next;
    logic [mlsd_pkg::BYTE_W-1:0]     cmd_reg,    cmd_next;
    logic [mlsd_pkg::BYTE_W-1:0]     len_reg,    len_next;
    logic [mlsd_pkg::BYTE_W-1:0]     rsum_reg,   rsum_next;
    logic                            out_valid_reg;
    logic [mlsd_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                            pvalid_reg, pvalid_next;
    logic [mlsd_pkg::BYTE_W-1:0]     pbyte_reg,  pbyte_next;
    logic [mlsd_pkg::BYTE_W-1:0]     pindex_reg, pindex_next;
    logic [mlsd_pkg::BYTE_W-1:0]     remain_dec;

    assign pop           = head_valid && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {len_reg, cmd_reg, pindex_reg, pbyte_reg};
    assign m_axis_tuser  = {pvalid_reg, status_reg};
    assign remain_dec    = remain_reg - 8'd1;

    always_comb begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        remain_next = remain_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        rsum_next   = rsum_reg;
        status_next = mlsd_pkg::ST_PROGRESS;
        pvalid_next = 1'b0;
        pbyte_next  = '0;
        pindex_next = '0;
        case (phase_reg)
            PH_HUNT: begin
                if (head_entry.is_start) begin
                    sum_next   = head_entry.data;
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_next   = head_entry.data;
                sum_next   = sum_reg + head_entry.data;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next    = head_entry.data;
                sum_next    = sum_reg + head_entry.data;
                remain_next = head_entry.data;
                phase_next  = head_entry.is_zero ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                pvalid_next = 1'b1;
                pbyte_next  = head_entry.data;
                pindex_next = len_reg - remain_reg;
                sum_next    = sum_reg + head_entry.data;
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM: begin
                rsum_next  = head_entry.data;
                phase_next = PH_END;
            end
            PH_END: begin
                status_next = (head_entry.is_end && (rsum_reg == sum_reg)) ?
                              mlsd_pkg::ST_GOOD : mlsd_pkg::ST_ERROR;
                phase_next  = PH_HUNT;
                sum_next    = '0;
                remain_next = '0;
            end
            default: begin
                status_next = mlsd_pkg::ST_ERROR;
                phase_next  = PH_HUNT;
                sum_next    = '0;
                remain_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= '0;
            remain_reg    <= '0;
            cmd_reg       <= '0;
            len_reg       <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
                remain_reg    <= remain_next;
                cmd_reg       <= cmd_next;
                len_reg       <= len_next;
                rsum_reg      <= rsum_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
        end
    end

    `ASSERT_CLK(a_end_returns, aclk, aresetn, (pop && (phase_reg == PH_END)) |=> ((phase_reg == PH_HUNT) && (status_reg != mlsd_pkg::ST_PROGRESS)), "end of packet did not report and return to hunting")
    `ASSERT_NEVER(a_payload_status, aclk, aresetn, out_valid_reg && pvalid_reg && (status_reg != mlsd_pkg::ST_PROGRESS), "payload beat carries a completion status")

endmodule

/* design/marker_length_sum_deframer_unit.sv */
// Path: an accepted byte is written into the queue; its result beat is registered in the back
// end when the byte is popped. Throughput: one byte per cycle, sustained while m_axis_tready
// stays high; the back end updates its state once per popped byte. During an output stall the
// two-entry queue fills and s_axis_tready drops in the cycle after m_axis_tready does, in steady flow.
// Reset: synchronous, active-low aresetn empties the queue, sets hunting, clears sums and
// held fields, and loads start_marker 0xAA and end_marker 0x55.
`timescale 1ns / 1ps
module marker_length_sum_deframer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mlsd_pkg::BYTE_W-1:0]        s_axis_tdata,  // rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mlsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // payload_byte, payload_index, command_id, payload_length
    output logic [mlsd_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // status, payload_valid
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mlsd_pkg::BYTE_W-1:0]        cfg_data
);

    logic              queue_full;
    logic              push;
    mlsd_pkg::entry_t  push_entry;
    logic              pop;
    logic              head_valid;
    mlsd_pkg::entry_t  head_entry;

    mlsd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    mlsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mlsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* bench/tb_marker_length_sum_deframer_unit.sv */
// self-checking testbench for the marker/length/sum packet deframer
`timescale 1ns / 1ps
module tb_marker_length_sum_deframer_unit;

    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD  = 60;
    localparam int N_ROWS     = 21;
    localparam logic [mlsd_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT, PH_CMD, PH_LEN, PH_DATA, PH_CSUM, PH_TAIL
    } deframe_phase_t;

    typedef enum int {FAULT_NONE, FAULT_SUM, FAULT_TAIL, FAULT_CUT} fault_t;

    typedef struct packed {
        logic [mlsd_pkg::STATUS_W-1:0] status;
        logic                          has_payload;
        logic [mlsd_pkg::BYTE_W-1:0]   data;
        logic [mlsd_pkg::BYTE_W-1:0]   index;
        logic [mlsd_pkg::BYTE_W-1:0]   command;
        logic [mlsd_pkg::BYTE_W-1:0]   length;
    } deframe_result_t;

    typedef struct packed {
        logic [mlsd_pkg::BYTE_W-1:0] rx;
        logic                        typed;
        deframe_result_t             want;
    } dir_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [mlsd_pkg::BYTE_W-1:0]      s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [mlsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [mlsd_pkg::OUT_USER_W-1:0]  m_axis_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [mlsd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mlsd_pkg::BYTE_W-1:0]      cfg_data;

    marker_length_sum_deframer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // model state
    logic [mlsd_pkg::BYTE_W-1:0] cfg_start;
    logic [mlsd_pkg::BYTE_W-1:0] cfg_end;
    deframe_phase_t              phase;
    logic [mlsd_pkg::BYTE_W-1:0] run_sum;
    logic [mlsd_pkg::BYTE_W-1:0] remaining;
    logic [mlsd_pkg::BYTE_W-1:0] held_cmd;
    logic [mlsd_pkg::BYTE_W-1:0] held_len;
    logic [mlsd_pkg::BYTE_W-1:0] rx_sum;

    deframe_result_t pending_results[$];
    int  mismatches = 0;
    int  bytes_fed = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  sender_steady = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    // directed rows, default markers after reset
    dir_row_t dir_rows [0:N_ROWS-1] = '{
        '{8'h00, 1'b1, '{mlsd_pkg::ST_PROGRESS, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 1'b1, '{mlsd_pkg::ST_PROGRESS, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hAA, 1'b1, '{mlsd_pkg::ST_PROGRESS, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},                                              // zero length
        '{8'hA9, 1'b0, '0},
        '{8'h55, 1'b1, '{mlsd_pkg::ST_GOOD, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00}},
        '{8'h13, 1'b1, '{mlsd_pkg::ST_PROGRESS, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00}},
        '{8'hAA, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},                                              // wrong checksum
        '{8'h55, 1'b1, '{mlsd_pkg::ST_ERROR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h02}},
        '{8'hAA, 1'b0, '0},
        '{8'h81, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h7E, 1'b0, '0},
        '{8'hAA, 1'b0, '0},                                              // sum matches
        '{8'h54, 1'b1, '{mlsd_pkg::ST_ERROR, 1'b0, 8'h00, 8'h00, 8'h81, 8'h01}}  // bad end
    };

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic deframe_result_t deframe_step(input logic [mlsd_pkg::BYTE_W-1:0] b);
        deframe_result_t r;
        r = '0;
        case (phase)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    run_sum = b;
                    phase = PH_CMD;
                end
            end
            PH_CMD: begin
                held_cmd = b;
                run_sum = run_sum + b;
                phase = PH_LEN;
            end
            PH_LEN: begin
                held_len = b;
                run_sum = run_sum + b;
                remaining = b;
                phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                r.has_payload = 1'b1;
                r.data = b;
                r.index = held_len - remaining;
                run_sum = run_sum + b;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) phase = PH_CSUM;
            end
            PH_CSUM: begin
                rx_sum = b;
                phase = PH_TAIL;
            end
            default: begin
                if (phase == PH_TAIL && b == cfg_end && rx_sum == run_sum)
                    r.status = mlsd_pkg::ST_GOOD;
                else
                    r.status = mlsd_pkg::ST_ERROR;
                phase = PH_HUNT;
                run_sum = '0;
                remaining = '0;
            end
        endcase
        r.command = held_cmd;
        r.length = held_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic check_result(input deframe_result_t got);
        deframe_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 0, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        if (got.has_payload !== want.has_payload)
            report_mismatch("payload_valid", int'(got.has_payload), int'(want.has_payload));
        if (got.data !== want.data)
            report_mismatch("payload_byte", int'(got.data), int'(want.data));
        if (got.index !== want.index)
            report_mismatch("payload_index", int'(got.index), int'(want.index));
        if (got.command !== want.command)
            report_mismatch("command_id", int'(got.command), int'(want.command));
        if (got.length !== want.length)
            report_mismatch("payload_length", int'(got.length), int'(want.length));
    endtask

    // receiver: checks beats and stalls
    initial begin
        deframe_result_t got;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser[1:0];
                got.has_payload = m_axis_tuser[2];
                got.data = m_axis_tdata[7:0];
                got.index = m_axis_tdata[15:8];
                got.command = m_axis_tdata[23:16];
                got.length = m_axis_tdata[31:24];
                check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_rx(input logic [mlsd_pkg::BYTE_W-1:0] b, input bit typed = 1'b0,
                           input deframe_result_t want = '0);
        deframe_result_t pred;
        if (!quiet && !sender_steady && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_axis_tdata <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pred = deframe_step(b);
        pending_results.push_back(typed ? want : pred);
        bytes_fed++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mlsd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mlsd_pkg::BYTE_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == mlsd_pkg::REG_START_MARKER) cfg_start = val;
        else if (idx == mlsd_pkg::REG_END_MARKER) cfg_end = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_packet(input int len, input fault_t fault);
        logic [mlsd_pkg::BYTE_W-1:0] sum;
        logic [mlsd_pkg::BYTE_W-1:0] b;
        int n_data;
        sum = cfg_start;
        send_rx(cfg_start);
        b = 8'($urandom);
        sum = sum + b;
        send_rx(b);
        sum = sum + len[7:0];
        send_rx(len[7:0]);
        n_data = (fault == FAULT_CUT) ? $urandom_range(0, len) : len;
        for (int i = 0; i < n_data; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            send_rx(b);
        end
        if (fault == FAULT_CUT) return;
        if (fault == FAULT_SUM) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_rx(sum);
        b = cfg_end;
        if (fault == FAULT_TAIL) b = b ^ 8'($urandom_range(1, 255));
        send_rx(b);
    endtask

    task automatic send_random_packet();
        int r;
        int len;
        fault_t fault;
        repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
        r = $urandom_range(0, 19);
        if (r < 14) len = $urandom_range(0, 8);
        else if (r < 19) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 120);
        r = $urandom_range(0, 15);
        if (r < 2) fault = FAULT_SUM;
        else if (r < 4) fault = FAULT_TAIL;
        else if (r == 4) fault = FAULT_CUT;
        else fault = FAULT_NONE;
        send_packet(len, fault);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cfg_start = mlsd_pkg::START_MARKER_RST;
        cfg_end = mlsd_pkg::END_MARKER_RST;
        phase = PH_HUNT;
        run_sum = '0;
        remaining = '0;
        held_cmd = '0;
        held_len = '0;
        rx_sum = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send_rx(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: begin
                    write_reg(mlsd_pkg::REG_START_MARKER, 8'h00);
                    write_reg(mlsd_pkg::REG_END_MARKER, 8'hFF);
                end
                1: begin
                    write_reg(mlsd_pkg::REG_START_MARKER, 8'hFF);
                    write_reg(mlsd_pkg::REG_END_MARKER, 8'h00);
                end
                2: begin
                    write_reg(mlsd_pkg::REG_START_MARKER, 8'h3C);
                    write_reg(mlsd_pkg::REG_END_MARKER, 8'h3C);
                end
                5: begin
                    write_reg(mlsd_pkg::REG_START_MARKER, mlsd_pkg::START_MARKER_RST);
                    write_reg(mlsd_pkg::REG_END_MARKER, mlsd_pkg::END_MARKER_RST);
                end
                default: begin
                    write_reg(mlsd_pkg::REG_START_MARKER, 8'($urandom));
                    write_reg(mlsd_pkg::REG_END_MARKER, 8'($urandom));
                    if (p == 4) write_reg(REG_UNUSED, 8'($urandom));
                end
            endcase
            quiet = (p == 5);
            if (p == 1) begin
                // long output stall while bytes keep coming
                sender_steady = 1;
                hold_req = 1;
                send_packet(20, FAULT_NONE);
                sender_steady = 0;
            end
            if (p == 2) send_packet(255, FAULT_NONE);
            while (bytes_fed < N_ROWS + (p + 1) * 105) send_random_packet();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/mlsd_pkg.sv
design/mlsd_front.sv
design/mlsd_queue.sv
design/mlsd_back.sv
design/marker_length_sum_deframer_unit.sv
bench/tb_marker_length_sum_deframer_unit.sv
